// ----- design/bcm_pkg.sv -----
// Shared widths, constants and the queued query word type.
`default_nettype none
package bcm_pkg;
    localparam int MW = 30;          // result value width
    localparam int NW = 20;          // argument width
    localparam int MM_LAT = 5;       // modular multiplier latency
    localparam int FQ_DEPTH = 4;     // front queue depth
    localparam int FQ_AW = 2;

    // classified query word
    typedef struct packed {
        logic          ok;       // 0 <= n < TABLE_SIZE
        logic          kv;       // 0 <= k <= n
        logic [NW-1:0] n_addr;
        logic [NW-1:0] d_addr;
        logic [NW-1:0] k_addr;
    } t_query;
endpackage
`default_nettype wire

// ----- design/bcm_mulmod.sv -----
// Pipelined a*b mod MODULUS, Barrett reduction, five stages.
`default_nettype none
module bcm_mulmod #(
    parameter int MODULUS = 998244353
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [bcm_pkg::MW-1:0] i_a,
    input  wire logic [bcm_pkg::MW-1:0] i_b,
    output logic                      o_valid,
    output logic [bcm_pkg::MW-1:0]    o_r
);
    import bcm_pkg::*;

    localparam int K = $clog2(MODULUS);
    localparam logic [MW:0] MU = (MW+1)'((64'd1 << (2*K)) / 64'(MODULUS));
    localparam logic [MW+1:0] MODW = (MW+2)'(MODULUS);

    logic [MM_LAT-1:0]  r_vld;
    logic [2*MW-1:0]    r_x;
    logic [MW:0]        r_q2;
    logic [MW+1:0]      r_xl2, r_xl3, r_qm, r_r;
    logic [MW-1:0]      r_out;
    logic [MW:0]        q1;
    logic [2*MW+1:0]    qmu;
    logic [2*MW:0]      qmf;
    logic [MW+1:0]      t1, t2;

    // quotient estimate and corrections
    always_comb begin
        q1  = (MW+1)'(r_x >> (K-1));
        qmu = (2*MW+2)'(q1) * (2*MW+2)'(MU);
        qmf = (2*MW+1)'(r_q2) * (2*MW+1)'(MODULUS);
        t1  = (r_r >= MODW) ? r_r - MODW : r_r;
        t2  = (t1 >= MODW) ? t1 - MODW : t1;
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= (2*MW)'(i_a) * (2*MW)'(i_b);
            r_q2  <= (MW+1)'(qmu >> (K+1));
            r_xl2 <= r_x[MW+1:0];
            r_qm  <= qmf[MW+1:0];
            r_xl3 <= r_xl2;
            r_r   <= r_xl3 - r_qm;
            r_out <= t2[MW-1:0];
        end
    end

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[MM_LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[MM_LAT-1];
    assign o_r     = r_out;
endmodule
`default_nettype wire

// ----- design/bcm_div.sv -----
// Bit-serial divider: MODULUS divided by a table index, one bit per cycle.
`default_nettype none
module bcm_div #(
    parameter int MODULUS = 998244353
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [bcm_pkg::MW:0] i_divisor,
    output logic                      o_done,
    output logic [bcm_pkg::MW-1:0]    o_quo,
    output logic [bcm_pkg::MW-1:0]    o_rem
);
    import bcm_pkg::*;

    localparam int CW = $clog2(MW+1);

    logic [MW:0]   r_rem;
    logic [MW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [MW:0]   trial;
    logic          ge;

    always_comb begin
        trial = {r_rem[MW-1:0], r_quo[MW-1]};
        ge    = (trial >= i_divisor);
    end

    // restoring division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= MW'(MODULUS);
        end else if (r_busy) begin
            r_rem <= ge ? trial - i_divisor : trial;
            r_quo <= {r_quo[MW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[MW-1:0];
endmodule
`default_nettype wire

// ----- design/bcm_tables.sv -----
// Factorial, inverse and inverse factorial tables with their build sequencer.
`default_nettype none
module bcm_tables #(
    parameter int TABLE_SIZE = 4096,
    parameter int MODULUS    = 998244353,
    parameter int IW         = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    output logic                      o_tables_ready,
    input  wire logic                 i_rd_en,
    input  wire logic [IW-1:0]        i_n_addr,
    input  wire logic [IW-1:0]        i_d_addr,
    input  wire logic [IW-1:0]        i_k_addr,
    output logic [bcm_pkg::MW-1:0]    o_fact,
    output logic [bcm_pkg::MW-1:0]    o_ifd,
    output logic [bcm_pkg::MW-1:0]    o_ifk
);
    import bcm_pkg::*;

    localparam logic [3:0] S_INIT0 = 4'd0;
    localparam logic [3:0] S_INIT1 = 4'd1;
    localparam logic [3:0] S_DIVGO = 4'd2;
    localparam logic [3:0] S_DIVW  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_W1    = 4'd6;
    localparam logic [3:0] S_M2    = 4'd7;
    localparam logic [3:0] S_W2    = 4'd8;
    localparam logic [3:0] S_M3    = 4'd9;
    localparam logic [3:0] S_W3    = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    localparam logic [MW-1:0] MODV = MW'(MODULUS);
    localparam logic [MW-1:0] ONE  = MW'(1);

    logic [MW-1:0] r_fact_mem [TABLE_SIZE];
    logic [MW-1:0] r_ifact_mem [TABLE_SIZE];
    logic [MW-1:0] r_inv_mem [TABLE_SIZE];

    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [MW-1:0] r_imod, r_fact_prev, r_ifact_prev, r_inv, r_ifact_new, r_inv_rd;
    logic [MW-1:0] r_fact, r_ifd, r_ifk;

    logic          div_start, div_done;
    logic [MW-1:0] div_quo, div_rem;
    logic          mm_vin, mm_vout;
    logic [MW-1:0] mm_a, mm_b, mm_r;
    logic          we;
    logic [IW-1:0] w_addr;
    logic [MW-1:0] w_fact, w_ifact, w_inv;

    bcm_div #(.MODULUS(MODULUS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_divisor((MW+1)'(r_idx)),
        .o_done   (div_done),
        .o_quo    (div_quo),
        .o_rem    (div_rem)
    );

    bcm_mulmod #(.MODULUS(MODULUS)) u_mm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (1'b1),
        .i_valid(mm_vin),
        .i_a    (mm_a),
        .i_b    (mm_b),
        .o_valid(mm_vout),
        .o_r    (mm_r)
    );

    // build sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        mm_vin    = 1'b0;
        mm_a      = r_fact_prev;
        mm_b      = r_imod;
        we        = 1'b0;
        w_addr    = r_idx;
        w_fact    = mm_r;
        w_ifact   = r_ifact_new;
        w_inv     = r_inv;
        unique case (r_state)
            S_INIT0: begin
                we      = 1'b1;
                w_addr  = '0;
                w_fact  = ONE;
                w_ifact = ONE;
                w_inv   = '0;
                n_state = S_INIT1;
            end
            S_INIT1: begin
                we      = 1'b1;
                w_addr  = IW'(1);
                w_fact  = ONE;
                w_ifact = ONE;
                w_inv   = ONE;
                n_state = (TABLE_SIZE == 2) ? S_DONE : S_DIVGO;
            end
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW:  if (div_done) n_state = S_RD;
            S_RD:    n_state = S_M1;
            S_M1: begin
                mm_vin  = 1'b1;
                mm_a    = r_inv_rd;
                mm_b    = div_quo;
                n_state = S_W1;
            end
            S_W1:    if (mm_vout) n_state = S_M2;
            S_M2: begin
                mm_vin  = 1'b1;
                mm_a    = r_ifact_prev;
                mm_b    = r_inv;
                n_state = S_W2;
            end
            S_W2:    if (mm_vout) n_state = S_M3;
            S_M3: begin
                mm_vin  = 1'b1;
                n_state = S_W3;
            end
            S_W3: begin
                if (mm_vout) begin
                    we      = 1'b1;
                    n_state = (r_idx == IW'(TABLE_SIZE-1)) ? S_DONE : S_DIVGO;
                end
            end
            S_DONE:  n_state = S_DONE;
            default: n_state = S_INIT0;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT0;
            r_idx        <= IW'(2);
            r_imod       <= MW'(2);
            r_fact_prev  <= ONE;
            r_ifact_prev <= ONE;
        end else begin
            r_state <= n_state;
            if (r_state == S_W3 && mm_vout) begin
                r_idx        <= r_idx + IW'(1);
                r_imod       <= (r_imod == MODV - ONE) ? '0 : r_imod + ONE;
                r_fact_prev  <= mm_r;
                r_ifact_prev <= r_ifact_new;
            end
        end
    end

    // build datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_W1 && mm_vout) begin
            r_inv <= (mm_r == '0) ? '0 : MODV - mm_r;
        end
        if (r_state == S_W2 && mm_vout) begin
            r_ifact_new <= mm_r;
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_fact_mem[w_addr]  <= w_fact;
            r_ifact_mem[w_addr] <= w_ifact;
            r_inv_mem[w_addr]   <= w_inv;
        end
    end

    // inverse read for the recurrence
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_inv_rd <= r_inv_mem[div_rem[IW-1:0]];
        end
    end

    // query reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fact <= r_fact_mem[i_n_addr];
            r_ifd  <= r_ifact_mem[i_d_addr];
            r_ifk  <= r_ifact_mem[i_k_addr];
        end
    end

    assign o_tables_ready = (r_state == S_DONE);
    assign o_fact = r_fact;
    assign o_ifd  = r_ifd;
    assign o_ifk  = r_ifk;
endmodule
`default_nettype wire

// ----- design/bcm_front.sv -----
// Front end: accepts queries, classifies them and queues the words.
`default_nettype none
module bcm_front #(
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tables_ready,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [bcm_pkg::NW-1:0] i_n_value,
    input  wire logic [bcm_pkg::NW-1:0] i_k_value,
    output logic                       o_q_valid,
    output bcm_pkg::t_query            o_q,
    input  wire logic                  i_pop
);
    import bcm_pkg::*;

    t_query          r_fifo [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, r_rp;
    logic [FQ_AW:0]   r_cnt;
    t_query          cls;
    logic            push, pop, ok, kv;
    logic [NW-1:0]   d;

    // classify
    always_comb begin
        ok = !i_n_value[NW-1] && (i_n_value < NW'(TABLE_SIZE));
        kv = !i_k_value[NW-1] && ($signed(i_k_value) <= $signed(i_n_value));
        d  = i_n_value - i_k_value;
        cls.ok     = ok;
        cls.kv     = kv;
        cls.n_addr = ok ? i_n_value : '0;
        cls.d_addr = (ok && kv) ? d : '0;
        cls.k_addr = (ok && kv) ? i_k_value : '0;
    end

    assign o_ready   = i_tables_ready && (r_cnt != (FQ_AW+1)'(FQ_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_pop && o_q_valid;
    assign o_q       = r_fifo[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + FQ_AW'(1);
            if (pop)  r_rp <= r_rp + FQ_AW'(1);
            r_cnt <= r_cnt + (FQ_AW+1)'(push) - (FQ_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_fifo[r_wp] <= cls;
    end
endmodule
`default_nettype wire

// ----- design/bcm_back.sv -----
// Back end: table reads, P = n!*ifact[n-k], C = P*ifact[k], output register.
`default_nettype none
module bcm_back #(
    parameter int MODULUS = 998244353,
    parameter int IW      = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire bcm_pkg::t_query      i_q,
    output logic                      o_pop,
    output logic                      o_rd_en,
    output logic [IW-1:0]             o_n_addr,
    output logic [IW-1:0]             o_d_addr,
    output logic [IW-1:0]             o_k_addr,
    input  wire logic [bcm_pkg::MW-1:0] i_fact,
    input  wire logic [bcm_pkg::MW-1:0] i_ifd,
    input  wire logic [bcm_pkg::MW-1:0] i_ifk,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [bcm_pkg::MW-1:0]    o_binomial,
    output logic [bcm_pkg::MW-1:0]    o_permutation,
    output logic [bcm_pkg::MW-1:0]    o_factorial,
    output logic                      o_in_range
);
    import bcm_pkg::*;

    logic          en;
    logic          r_s0_valid, r_s0_ok, r_s0_kv;
    logic [MW-1:0] r_sb1_f [MM_LAT];
    logic [MW-1:0] r_sb1_k [MM_LAT];
    logic          r_sb1_ok [MM_LAT];
    logic          r_sb1_kv [MM_LAT];
    logic [MW-1:0] r_sb2_f [MM_LAT];
    logic [MW-1:0] r_sb2_p [MM_LAT];
    logic          r_sb2_ok [MM_LAT];
    logic          r_sb2_kv [MM_LAT];
    logic          mm1_v, mm2_v;
    logic [MW-1:0] mm1_r, mm2_r;
    logic          r_out_valid, r_ok;
    logic [MW-1:0] r_c, r_p, r_f;

    // whole pipe advances unless the output word is held
    assign en       = !r_out_valid || i_ready;
    assign o_pop    = en;
    assign o_rd_en  = en;
    assign o_n_addr = i_q.n_addr[IW-1:0];
    assign o_d_addr = i_q.d_addr[IW-1:0];
    assign o_k_addr = i_q.k_addr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ok <= i_q.ok;
            r_s0_kv <= i_q.kv;
        end
    end

    bcm_mulmod #(.MODULUS(MODULUS)) u_mm_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_s0_valid),
        .i_a    (i_fact),
        .i_b    (i_ifd),
        .o_valid(mm1_v),
        .o_r    (mm1_r)
    );

    bcm_mulmod #(.MODULUS(MODULUS)) u_mm_c (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(mm1_v),
        .i_a    (mm1_r),
        .i_b    (r_sb1_k[MM_LAT-1]),
        .o_valid(mm2_v),
        .o_r    (mm2_r)
    );

    // sideband alongside the multipliers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb1_f[0]  <= i_fact;
            r_sb1_k[0]  <= i_ifk;
            r_sb1_ok[0] <= r_s0_ok;
            r_sb1_kv[0] <= r_s0_kv;
            r_sb2_f[0]  <= r_sb1_f[MM_LAT-1];
            r_sb2_p[0]  <= mm1_r;
            r_sb2_ok[0] <= r_sb1_ok[MM_LAT-1];
            r_sb2_kv[0] <= r_sb1_kv[MM_LAT-1];
            for (int i = 1; i < MM_LAT; i++) begin
                r_sb1_f[i]  <= r_sb1_f[i-1];
                r_sb1_k[i]  <= r_sb1_k[i-1];
                r_sb1_ok[i] <= r_sb1_ok[i-1];
                r_sb1_kv[i] <= r_sb1_kv[i-1];
                r_sb2_f[i]  <= r_sb2_f[i-1];
                r_sb2_p[i]  <= r_sb2_p[i-1];
                r_sb2_ok[i] <= r_sb2_ok[i-1];
                r_sb2_kv[i] <= r_sb2_kv[i-1];
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mm2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok <= r_sb2_ok[MM_LAT-1];
            r_f  <= r_sb2_ok[MM_LAT-1] ? r_sb2_f[MM_LAT-1] : '0;
            r_p  <= (r_sb2_ok[MM_LAT-1] && r_sb2_kv[MM_LAT-1]) ? r_sb2_p[MM_LAT-1] : '0;
            r_c  <= (r_sb2_ok[MM_LAT-1] && r_sb2_kv[MM_LAT-1]) ? mm2_r : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_binomial    = r_c;
    assign o_permutation = r_p;
    assign o_factorial   = r_f;
    assign o_in_range    = r_ok;
endmodule
`default_nettype wire

// ----- design/binomial_coefficient_mod_prime_core.sv -----
// Top level: C(n,k), P(n,k) and n! modulo a prime from built tables.
// After reset the core builds its factorial, inverse and inverse factorial
// tables one entry at a time: each entry runs a bit-serial division of the
// modulus by the index, one table read and three modular multiplies in turn.
// No query is taken until the tables are built.
// Afterwards one query is accepted per cycle while the four-deep input queue
// has room; each word that leaves the queue passes through the table read,
// the two chained Barrett multipliers and the output register.
`default_nettype none
module binomial_coefficient_mod_prime_core #(
    parameter int TABLE_SIZE = 4096,
    parameter int MODULUS    = 998244353
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [bcm_pkg::NW-1:0] i_n_value,
    input  wire logic [bcm_pkg::NW-1:0] i_k_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [bcm_pkg::MW-1:0]      o_binomial,
    output logic [bcm_pkg::MW-1:0]      o_permutation,
    output logic [bcm_pkg::MW-1:0]      o_factorial,
    output logic                        o_in_range
);
    import bcm_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    logic          tables_ready, q_valid, pop, rd_en;
    t_query        q;
    logic [IW-1:0] n_addr, d_addr, k_addr;
    logic [MW-1:0] fact, ifd, ifk;

    bcm_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tables_ready(tables_ready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_n_value     (i_n_value),
        .i_k_value     (i_k_value),
        .o_q_valid     (q_valid),
        .o_q           (q),
        .i_pop         (pop)
    );

    bcm_tables #(.TABLE_SIZE(TABLE_SIZE), .MODULUS(MODULUS), .IW(IW)) u_tables (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_tables_ready(tables_ready),
        .i_rd_en       (rd_en),
        .i_n_addr      (n_addr),
        .i_d_addr      (d_addr),
        .i_k_addr      (k_addr),
        .o_fact        (fact),
        .o_ifd         (ifd),
        .o_ifk         (ifk)
    );

    bcm_back #(.MODULUS(MODULUS), .IW(IW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q          (q),
        .o_pop        (pop),
        .o_rd_en      (rd_en),
        .o_n_addr     (n_addr),
        .o_d_addr     (d_addr),
        .o_k_addr     (k_addr),
        .i_fact       (fact),
        .i_ifd        (ifd),
        .i_ifk        (ifk),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_binomial   (o_binomial),
        .o_permutation(o_permutation),
        .o_factorial  (o_factorial),
        .o_in_range   (o_in_range)
    );
endmodule
`default_nettype wire

// ----- design/bcm_checker.sv -----
// Port-level checks for the core, bound to the top level.
`default_nettype none
module bcm_checker #(
    parameter int MODULUS = 998244353
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [bcm_pkg::MW-1:0] o_binomial,
    input wire logic [bcm_pkg::MW-1:0] o_permutation,
    input wire logic [bcm_pkg::MW-1:0] o_factorial,
    input wire logic                   o_in_range
);
    import bcm_pkg::*;

    // a held result word keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_binomial)
            && $stable(o_permutation) && $stable(o_factorial) && $stable(o_in_range))
        else $error("result word changed while stalled");

    // out of range gives all zeros
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_range |-> o_binomial == '0 && o_permutation == '0
            && o_factorial == '0)
        else $error("out-of-range query with nonzero value");

    // values are reduced
    a_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_binomial < MW'(MODULUS) && o_permutation < MW'(MODULUS)
            && o_factorial < MW'(MODULUS))
        else $error("value not reduced");

    // nonzero C needs nonzero P
    a_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_binomial != '0 |-> o_permutation != '0)
        else $error("binomial without permutation");
endmodule

bind binomial_coefficient_mod_prime_core bcm_checker #(.MODULUS(MODULUS)) u_bcm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_binomial   (o_binomial),
    .o_permutation(o_permutation),
    .o_factorial  (o_factorial),
    .o_in_range   (o_in_range)
);
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the binomial / permutation / factorial modulo-prime core.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE = 4096;
    localparam longint PRIME = 998244353;
    localparam int NW = bcm_pkg::NW;
    localparam int MW = bcm_pkg::MW;

    typedef struct packed {
        logic [MW-1:0] binom;
        logic [MW-1:0] perm;
        logic [MW-1:0] fact;
        logic          in_rng;
    } t_answer;

    // directed row: query plus optional typed-in answer
    typedef struct {
        int      n;
        int      k;
        bit      known;
        t_answer ans;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [NW-1:0] i_n_value;
    logic [NW-1:0] i_k_value;
    logic          o_valid;
    logic          i_ready;
    logic [MW-1:0] o_binomial;
    logic [MW-1:0] o_permutation;
    logic [MW-1:0] o_factorial;
    logic          o_in_range;

    binomial_coefficient_mod_prime_core DUT (.*);

    // local copies of the tables
    longint fact_tbl [TSIZE];
    longint inv_tbl  [TSIZE];
    longint ifact_tbl[TSIZE];

    t_answer pending_answers[$];
    int      errors;
    bit      sending_done;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // build tables with the same recurrences as the core
    function automatic void build_tables();
        longint inv;
        fact_tbl[0] = 1; fact_tbl[1] = 1;
        ifact_tbl[0] = 1; ifact_tbl[1] = 1;
        inv_tbl[0] = 0; inv_tbl[1] = 1;
        for (int i = 2; i < TSIZE; i++) begin
            fact_tbl[i] = (fact_tbl[i-1] * (i % PRIME)) % PRIME;
            inv = PRIME - (inv_tbl[PRIME % i] * ((PRIME / i) % PRIME)) % PRIME;
            if (inv == PRIME) inv = 0;
            inv_tbl[i] = inv;
            ifact_tbl[i] = (ifact_tbl[i-1] * inv) % PRIME;
        end
    endfunction

    function automatic t_answer combine_query(logic [NW-1:0] nv, logic [NW-1:0] kv);
        t_answer a;
        int n, k;
        longint p;
        n = int'(signed'(nv));
        k = int'(signed'(kv));
        a = '0;
        if (n >= 0 && n < TSIZE) begin
            a.in_rng = 1'b1;
            a.fact = MW'(fact_tbl[n]);
            if (k >= 0 && k <= n) begin
                p = (fact_tbl[n] * ifact_tbl[n-k]) % PRIME;
                a.perm = MW'(p);
                a.binom = MW'((p * ifact_tbl[k]) % PRIME);
            end
        end
        return a;
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_query(int n, int k, bit known, t_answer ans);
        t_answer exp_ans;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        exp_ans = combine_query(NW'(n), NW'(k));
        if (known && exp_ans !== ans) begin
            $display("%0t: table mismatch n=%0d k=%0d expected %h actual %h",
                     $time, n, k, ans, exp_ans);
            errors++;
        end
        i_valid <= 1'b1;
        i_n_value <= NW'(n);
        i_k_value <= NW'(k);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_answers.push_back(exp_ans);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected word binom=%0d", $time, o_binomial);
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (o_binomial !== e.binom) begin
                    $display("%0t: binomial expected %0d actual %0d", $time, e.binom, o_binomial);
                    errors++;
                end
                if (o_permutation !== e.perm) begin
                    $display("%0t: permutation expected %0d actual %0d",
                             $time, e.perm, o_permutation);
                    errors++;
                end
                if (o_factorial !== e.fact) begin
                    $display("%0t: factorial expected %0d actual %0d", $time, e.fact, o_factorial);
                    errors++;
                end
                if (o_in_range !== e.in_rng) begin
                    $display("%0t: in_range expected %0b actual %0b", $time, e.in_rng, o_in_range);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_row rows[$];
        int n, k, sel;
        errors = 0;
        sending_done = 0;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_n_value = '0;
        i_k_value = '0;
        build_tables();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: extremes and special cases
        rows = '{
            '{0, 0, 1, '{1, 1, 1, 1}},
            '{1, 0, 1, '{1, 1, 1, 1}},
            '{1, 1, 1, '{1, 1, 1, 1}},
            '{3, 2, 1, '{3, 6, 6, 1}},
            '{5, 2, 1, '{10, 20, 120, 1}},
            '{-1, 0, 1, '{0, 0, 0, 0}},
            '{-524288, -524288, 1, '{0, 0, 0, 0}},
            '{524287, 524287, 1, '{0, 0, 0, 0}},
            '{TSIZE, 0, 1, '{0, 0, 0, 0}},
            '{4, -1, 1, '{0, 0, 24, 1}},
            '{4, 5, 1, '{0, 0, 24, 1}},
            '{4, 524287, 1, '{0, 0, 24, 1}},
            '{4, -524288, 1, '{0, 0, 24, 1}},
            '{TSIZE-1, 0, 0, '0},
            '{TSIZE-1, TSIZE-1, 0, '0},
            '{TSIZE-1, 2048, 0, '0},
            '{TSIZE-1, 1, 0, '0},
            '{2730, 1365, 0, '0},
            '{1365, 682, 0, '0}
        };
        foreach (rows[i]) send_query(rows[i].n, rows[i].k, rows[i].known, rows[i].ans);
        i_valid <= 1'b0;

        // let everything drain once
        while (pending_answers.size() != 0) @(posedge i_clk);

        // random queries, mostly in range
        for (int i = 0; i < 850; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                n = $urandom_range(0, TSIZE-1);
                k = $urandom_range(0, 5) == 0 ? n : $urandom_range(0, n);
            end else if (sel == 7) begin
                n = $urandom_range(0, TSIZE-1);
                k = int'(signed'(NW'($urandom)));
            end else begin
                n = int'(signed'(NW'($urandom)));
                k = int'(signed'(NW'($urandom)));
            end
            send_query(n, k, 0, '0);
        end
        i_valid <= 1'b0;
        sending_done = 1;
    end

    // end of run
    initial begin
        wait (sending_done);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: covers the table build, which takes far longer than the queries
    initial begin
        #(12ns * 1500000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
